FILE: rtl/bejm_pkg.sv
// Shared types and constants for the block equi-join matcher.
`timescale 1ns / 1ps
package bejm_pkg;

    localparam int KEY_W   = 64;
    localparam int IDX_W   = 6;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STS_LOADED   = 3'd0,
        STS_FULL     = 3'd1,
        STS_MATCH    = 3'd2,
        STS_NO_MATCH = 3'd3,
        STS_CLEARED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_INT32   = 2'd0,
        KIND_INT64   = 2'd1,
        KIND_FLOAT64 = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_KEY_COUNT = 1'b0,
        CFG_KEY_KINDS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WALK  = 2'd1,
        S_DRAIN = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key_0;
        logic [KEY_W-1:0] key_1;
        logic [KEY_W-1:0] key_2;
        logic [KEY_W-1:0] key_3;
        logic [3:0]       null_mask;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] outer_index;
        logic             last;
    } t_out;

    // Walk token carried alongside the lane pipeline
    typedef struct packed {
        logic             row;
        logic             flush;
        logic [IDX_W-1:0] idx;
    } t_tag;

    function automatic logic [KEY_W-1:0] key_sel(input t_in req, input logic [1:0] k);
        logic [KEY_W-1:0] v;
        case (k)
            2'd0: v = req.key_0;
            2'd1: v = req.key_1;
            2'd2: v = req.key_2;
            default: v = req.key_3;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/bejm_lane.sv
// One key-column lane: column storage and the per-kind equality compare.
`timescale 1ns / 1ps
module bejm_lane #(
    parameter int BLOCK_DEPTH = 64,
    parameter int AW          = 6
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [bejm_pkg::KEY_W-1:0] i_wkey,
    input  logic                   i_wnull,
    input  logic [AW-1:0]          i_raddr,
    input  logic [bejm_pkg::KEY_W-1:0] i_probe_key,
    input  logic [1:0]             i_kind,
    input  logic                   i_active,
    output logic                   o_eq
);
    import bejm_pkg::*;

    logic [KEY_W-1:0] mem_key [0:BLOCK_DEPTH-1];
    logic             mem_null [0:BLOCK_DEPTH-1];

    logic [KEY_W-1:0] r_rd_key;
    logic             r_rd_null;
    logic             r_eq;
    logic             cmp;
    logic             nan_a;
    logic             nan_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_key[i_waddr]  <= i_wkey;
            mem_null[i_waddr] <= i_wnull;
        end
        r_rd_key  <= mem_key[i_raddr];
        r_rd_null <= mem_null[i_raddr];
    end

    always_comb begin
        nan_a = (&r_rd_key[62:52]) && (|r_rd_key[51:0]);
        nan_b = (&i_probe_key[62:52]) && (|i_probe_key[51:0]);
        case (i_kind)
            KIND_INT32:   cmp = (r_rd_key[31:0] == i_probe_key[31:0]);
            KIND_FLOAT64: cmp = !nan_a && !nan_b &&
                                (((r_rd_key[62:0] == '0) && (i_probe_key[62:0] == '0)) ||
                                 (r_rd_key == i_probe_key));
            default:      cmp = (r_rd_key == i_probe_key);
        endcase
    end

    // Inactive columns never veto a row
    always_ff @(posedge i_clk) begin
        r_eq <= !i_active || (!r_rd_null && cmp);
    end

    assign o_eq = r_eq;

endmodule

FILE: rtl/bejm_merge.sv
// Merge stage: combines lane verdicts and orders match reports with the last mark.
`timescale 1ns / 1ps
module bejm_merge #(
    parameter int NLANES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bejm_pkg::t_tag    i_tag,
    input  logic [NLANES-1:0] i_eq,
    output logic              o_vld,
    output bejm_pkg::t_out    o_res
);
    import bejm_pkg::*;

    // One match is held back so the final one can carry last
    logic             r_pend_vld;
    logic [IDX_W-1:0] r_pend_idx;
    logic             n_pend_vld;
    logic [IDX_W-1:0] n_pend_idx;
    logic             hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else begin
            r_pend_vld <= n_pend_vld;
        end
        r_pend_idx <= n_pend_idx;
    end

    always_comb begin
        hit        = i_tag.row && (&i_eq);
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        o_vld      = 1'b0;
        o_res      = '0;
        if (hit) begin
            if (r_pend_vld) begin
                o_vld             = 1'b1;
                o_res.status      = STS_MATCH;
                o_res.outer_index = r_pend_idx;
            end
            n_pend_vld = 1'b1;
            n_pend_idx = i_tag.idx;
        end
        if (i_tag.flush) begin
            o_vld      = 1'b1;
            o_res.last = 1'b1;
            if (r_pend_vld) begin
                o_res.status      = STS_MATCH;
                o_res.outer_index = r_pend_idx;
            end else begin
                o_res.status = STS_NO_MATCH;
            end
            n_pend_vld = 1'b0;
        end
    end

endmodule

FILE: rtl/block_equi_join_matcher.sv
// Top level of the block equi-join matcher: control, config and result register.
`timescale 1ns / 1ps
// Load and clear requests are taken one per cycle while the block is idle and
// answer in the cycle after acceptance. A probe walks the stored rows one per
// cycle through MAX_KEYS column lanes (a memory read, a compare, then the
// merge), so busy stays high until its flush token reaches the merge; a
// probe with a null among the compared keys answers without a walk. Results
// appear on o_res for exactly one cycle with o_strobe high and cannot be held
// off, so the receiver must take every strobe. Matches come in ascending slot
// order; last marks the final result of each request.
module block_equi_join_matcher #(
    parameter int BLOCK_DEPTH = 64,
    parameter int MAX_KEYS    = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  bejm_pkg::t_in  i_req,
    output logic           o_strobe,
    output bejm_pkg::t_out o_res,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_data
);
    import bejm_pkg::*;

    localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int CW = $clog2(BLOCK_DEPTH + 1);

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_row_count;
    logic [CW-1:0]   n_row_count;
    logic [CW-1:0]   r_walk_cnt;
    logic [CW-1:0]   n_walk_cnt;
    logic [2:0]      r_key_count;
    logic [7:0]      r_key_kinds;
    t_in             r_probe;
    t_tag            s0_tag;
    t_tag            r_tag1;
    t_tag            r_tag2;
    logic            r_strobe;
    logic            n_strobe;
    t_out            r_res;
    t_out            n_res;

    logic            accept;
    logic            wr_en;
    logic [2:0]      nk;
    logic [MAX_KEYS-1:0] act;
    logic [MAX_KEYS-1:0] lane_eq;
    logic            m_vld;
    t_out            m_res;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // key_count 0 acts as one column, large values saturate at the lane count
    always_comb begin
        if (r_key_count == 3'd0) begin
            nk = 3'd1;
        end else if (r_key_count > 3'(MAX_KEYS)) begin
            nk = 3'(MAX_KEYS);
        end else begin
            nk = r_key_count;
        end
        for (int k = 0; k < MAX_KEYS; k++) begin
            act[k] = (3'(k) < nk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 3'd1;
            r_key_kinds <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_COUNT: r_key_count <= i_cfg_data[2:0];
                CFG_KEY_KINDS: r_key_kinds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= '0;
            r_walk_cnt  <= '0;
            r_tag1      <= '0;
            r_tag2      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_count <= n_row_count;
            r_walk_cnt  <= n_walk_cnt;
            r_tag1      <= s0_tag;
            r_tag2      <= r_tag1;
            r_strobe    <= n_strobe;
        end
        r_res <= n_res;
        if (accept) begin
            r_probe <= i_req;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row_count = r_row_count;
        n_walk_cnt  = r_walk_cnt;
        s0_tag      = '0;
        wr_en       = 1'b0;
        n_strobe    = m_vld;
        n_res       = m_res;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.command)
                        CMD_LOAD: begin
                            n_strobe   = 1'b1;
                            n_res      = '0;
                            n_res.last = 1'b1;
                            if (r_row_count >= CW'(BLOCK_DEPTH)) begin
                                n_res.status = STS_FULL;
                            end else begin
                                wr_en             = 1'b1;
                                n_res.status      = STS_LOADED;
                                n_res.outer_index = IDX_W'(r_row_count);
                                n_row_count       = CW'(r_row_count + 1'b1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_row_count  = '0;
                            n_strobe     = 1'b1;
                            n_res        = '0;
                            n_res.status = STS_CLEARED;
                            n_res.last   = 1'b1;
                        end
                        CMD_PROBE: begin
                            if (|(i_req.null_mask[MAX_KEYS-1:0] & act)) begin
                                n_strobe     = 1'b1;
                                n_res        = '0;
                                n_res.status = STS_NO_MATCH;
                                n_res.last   = 1'b1;
                            end else begin
                                n_walk_cnt = '0;
                                n_state    = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (r_walk_cnt < r_row_count) begin
                    s0_tag.row = 1'b1;
                    s0_tag.idx = IDX_W'(r_walk_cnt);
                    n_walk_cnt = CW'(r_walk_cnt + 1'b1);
                end else begin
                    // flush token closes the walk behind the last row
                    s0_tag.flush = 1'b1;
                    n_state      = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_tag2.flush) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    for (genvar k = 0; k < MAX_KEYS; k++) begin : g_lane
        bejm_lane #(
            .BLOCK_DEPTH (BLOCK_DEPTH),
            .AW          (AW)
        ) u_lane (
            .i_clk       (i_clk),
            .i_we        (wr_en),
            .i_waddr     (r_row_count[AW-1:0]),
            .i_wkey      (key_sel(i_req, 2'(k))),
            .i_wnull     (i_req.null_mask[k]),
            .i_raddr     (r_walk_cnt[AW-1:0]),
            .i_probe_key (key_sel(r_probe, 2'(k))),
            .i_kind      (r_key_kinds[2*k +: 2]),
            .i_active    (act[k]),
            .o_eq        (lane_eq[k])
        );
    end

    bejm_merge #(
        .NLANES (MAX_KEYS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag2),
        .i_eq    (lane_eq),
        .o_vld   (m_vld),
        .o_res   (m_res)
    );

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
